[src/hmm_pkg.sv]
`default_nettype none

package hmm_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [7:0] level_t;

    localparam cmd_t CMD_LOAD_IN  = 2'd0;
    localparam cmd_t CMD_LOAD_REF = 2'd1;
    localparam cmd_t CMD_BUILD    = 2'd2;
    localparam cmd_t CMD_MAP      = 2'd3;

endpackage

`default_nettype wire

[src/hmm_if.sv]
`default_nettype none

interface hmm_req_if import hmm_pkg::*;;
    logic   valid;
    logic   ready;
    cmd_t   cmd;
    level_t index;
    level_t entry_value;
    level_t pixel;

    modport source (output valid, output cmd, output index, output entry_value,
                    output pixel, input ready);
    modport sink   (input valid, input cmd, input index, input entry_value,
                    input pixel, output ready);
endinterface

interface hmm_rsp_if import hmm_pkg::*;;
    logic   valid;
    logic   ready;
    level_t mapped_pixel;

    modport source (output valid, output mapped_pixel, input ready);
    modport sink   (input valid, input mapped_pixel, output ready);
endinterface

`default_nettype wire

[src/histogram_matching_mapper.sv]
// Loads and map words: one per cycle while ready is high; a map result is read from the
// match table, then registered for output. A build walks LEVELS levels, each one read
// of T plus a scan of G through its single read port; no word is accepted during a build.
// Reset (rst_n low, asynchronous) clears control state and marks the match table as
// unbuilt, so maps return zero until the first build completes; T and G stay undefined.
`default_nettype none

module histogram_matching_mapper import hmm_pkg::*; #(
    parameter int LEVELS = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hmm_req_if.sink    req,
    hmm_rsp_if.source  rsp
);

    localparam int AW = $clog2(LEVELS);
    localparam int XW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST = AW'(LEVELS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LDT  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] r_reg, r_next;
    logic [AW-1:0] zd_reg, zd_next;
    logic          first_reg, first_next;
    logic          built_reg, built_next;
    logic          p1_valid_reg, p1_valid_next;
    logic          p1_zero_reg, p1_zero_next;
    logic          out_valid_reg, out_valid_next;
    level_t        out_data_reg, out_data_next;
    level_t        best_reg, best_next;
    logic [AW-1:0] bz_reg, bz_next;

    logic          t_we, g_we, m_we, t_re, g_re, m_re;
    logic [AW-1:0] ld_addr, g_raddr, px_addr;
    level_t        t_rdata, g_rdata, m_rdata, m_wdata;
    logic [XW-1:0] idx_x, pix_x, bz_x;
    logic          idx_ok, pix_ok, acc, map_acc, out_load;
    level_t        diff;
    logic          take;
    logic [AW-1:0] bz_sel;

    assign idx_x   = XW'(req.index);
    assign pix_x   = XW'(req.pixel);
    assign ld_addr = idx_x[AW-1:0];
    assign px_addr = pix_x[AW-1:0];
    assign idx_ok  = int'(req.index) < LEVELS;
    assign pix_ok  = int'(req.pixel) < LEVELS;

    assign out_load  = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE) && !(p1_valid_reg && !out_load);
    assign acc       = req.valid && req.ready;
    assign map_acc   = acc && (req.cmd == CMD_MAP);

    assign rsp.valid        = out_valid_reg;
    assign rsp.mapped_pixel = out_data_reg;

    assign diff   = (g_rdata >= t_rdata) ? (g_rdata - t_rdata) : (t_rdata - g_rdata);
    assign take   = first_reg || (diff < best_reg);
    assign bz_sel = take ? zd_reg : bz_reg;
    assign bz_x   = XW'(bz_sel);
    assign m_wdata = bz_x[7:0];

    hmm_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_tin (
        .clk(clk), .we(t_we), .waddr(ld_addr), .wdata(req.entry_value),
        .re(t_re), .raddr(r_reg), .rdata(t_rdata)
    );

    hmm_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_tref (
        .clk(clk), .we(g_we), .waddr(ld_addr), .wdata(req.entry_value),
        .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
    );

    hmm_ram #(.WIDTH(8), .DEPTH(LEVELS)) u_match (
        .clk(clk), .we(m_we), .waddr(r_reg), .wdata(m_wdata),
        .re(m_re), .raddr(px_addr), .rdata(m_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        zd_next    = zd_reg;
        first_next = first_reg;
        built_next = built_reg;
        best_next  = best_reg;
        bz_next    = bz_reg;
        t_we       = 1'b0;
        g_we       = 1'b0;
        m_we       = 1'b0;
        t_re       = 1'b0;
        g_re       = 1'b0;
        m_re       = 1'b0;
        g_raddr    = zd_reg + AW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (req.cmd)
                        CMD_LOAD_IN:  t_we = idx_ok;
                        CMD_LOAD_REF: g_we = idx_ok;
                        CMD_BUILD:
                        begin
                            r_next     = '0;
                            state_next = S_LDT;
                        end
                        CMD_MAP:      m_re = 1'b1;
                        default:      m_re = 1'b0;
                    endcase
                end
            end
            S_LDT:
            begin
                t_re       = 1'b1;
                g_re       = 1'b1;
                g_raddr    = '0;
                zd_next    = '0;
                first_next = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                first_next = 1'b0;
                bz_next    = bz_sel;
                best_next  = take ? diff : best_reg;
                if (zd_reg != LAST)
                begin
                    g_re    = 1'b1;
                    zd_next = zd_reg + AW'(1);
                end
                else
                begin
                    m_we = 1'b1;
                    if (r_reg == LAST)
                    begin
                        built_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + AW'(1);
                        state_next = S_LDT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        p1_valid_next  = map_acc || (p1_valid_reg && !out_load);
        p1_zero_next   = map_acc ? (!built_reg || !pix_ok) : p1_zero_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = p1_zero_reg ? '0 : m_rdata;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            zd_reg        <= '0;
            first_reg     <= 1'b0;
            built_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            zd_reg        <= zd_next;
            first_reg     <= first_next;
            built_reg     <= built_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_zero_reg  <= p1_zero_next;
        out_data_reg <= out_data_next;
        best_reg     <= best_next;
        bz_reg       <= bz_next;
    end

endmodule

`default_nettype wire

[src/hmm_ram.sv]
`default_nettype none

module hmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/hmm_checker.sv]
`default_nettype none

module hmm_checker import hmm_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   req_valid,
    input wire logic   req_ready,
    input wire cmd_t   req_cmd,
    input wire logic   rsp_valid,
    input wire logic   rsp_ready,
    input wire level_t rsp_data
);

    logic req_acc;
    assign req_acc = req_valid && req_ready;

    // held result word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word dropped or changed while stalled");

    assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

    // build occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req_cmd == CMD_BUILD |=> !req_ready)
        else $error("word accepted straight after build");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req_cmd == CMD_MAP && !rsp_valid |-> ##2 rsp_valid)
        else $error("map result late");

endmodule

bind histogram_matching_mapper hmm_checker u_hmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.mapped_pixel)
);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import hmm_pkg::*;

    localparam int LEVELS      = 256;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        cmd_t   cmd;
        level_t index;
        level_t entry_value;
        level_t pixel;
    } hmm_word_t;

    logic clk;
    logic rst_n;

    hmm_req_if req_bus ();
    hmm_rsp_if rsp_bus ();

    histogram_matching_mapper #(
        .LEVELS (LEVELS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    hmm_word_t words_to_send[$];
    level_t    mapped_due[$];

    level_t in_eq     [256];
    level_t ref_eq    [256];
    level_t match_lut [256];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int   req_gap   = 0;
    int   rsp_stall = 0;
    bit   req_quiet = 1'b0;
    bit   rsp_quiet = 1'b0;
    int   fault_count = 0;
    int   cycle_count = 0;

    task automatic rebuild_match_lut();
        int best_z;
        int best_diff;
        int diff;
        for (int r = 0; r < LEVELS; r++) begin
            best_z    = 0;
            best_diff = 1 << 20;
            for (int z = 0; z < LEVELS; z++) begin
                diff = (ref_eq[z] >= in_eq[r]) ? int'(ref_eq[z]) - int'(in_eq[r])
                                               : int'(in_eq[r]) - int'(ref_eq[z]);
                if (diff < best_diff) begin
                    best_diff = diff;
                    best_z    = z;
                end
            end
            match_lut[r] = level_t'(best_z);
        end
    endtask

    task automatic apply_word(hmm_word_t w);
        case (w.cmd)
            CMD_LOAD_IN:
                if (w.index < LEVELS)
                    in_eq[w.index] = w.entry_value;
            CMD_LOAD_REF:
                if (w.index < LEVELS)
                    ref_eq[w.index] = w.entry_value;
            CMD_BUILD:
                rebuild_match_lut();
            CMD_MAP:
                mapped_due.push_back((w.pixel < LEVELS) ? match_lut[w.pixel] : level_t'(0));
        endcase
    endtask

    task automatic send_load(cmd_t c, int idx, int val);
        hmm_word_t w;
        w.cmd         = c;
        w.index       = level_t'(idx);
        w.entry_value = level_t'(val);
        w.pixel       = level_t'($urandom);
        words_to_send.push_back(w);
    endtask

    task automatic send_map(int pix);
        hmm_word_t w;
        w.cmd         = CMD_MAP;
        w.index       = level_t'($urandom);
        w.entry_value = level_t'($urandom);
        w.pixel       = level_t'(pix);
        words_to_send.push_back(w);
    endtask

    task automatic send_build();
        hmm_word_t w;
        w.cmd         = CMD_BUILD;
        w.index       = level_t'($urandom);
        w.entry_value = level_t'($urandom);
        w.pixel       = level_t'($urandom);
        words_to_send.push_back(w);
    endtask

    task automatic send_random_load(int top);
        send_load($urandom_range(0, 1) ? CMD_LOAD_REF : CMD_LOAD_IN,
                  $urandom_range(0, 255), $urandom_range(0, top));
    endtask

    // partial table rewrite with stray maps, build, then mostly maps
    task automatic queue_random_round(int top);
        int n_loads;
        n_loads = $urandom_range(50, 70);
        for (int i = 0; i < n_loads; i++) begin
            if ($urandom_range(0, 6) == 0)
                send_map($urandom_range(0, 255));
            else
                send_random_load(top);
        end
        send_build();
        for (int i = 0; i < 75; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_random_load(top);
            else
                send_map($urandom_range(0, 255));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver: words change on the falling edge
    always @(negedge clk)
    begin
        hmm_word_t w;
        if (rst_n) begin
            if (req_bus.valid && req_taken) begin
                if ($urandom_range(0, 15) == 0)
                    req_quiet = !req_quiet;
                req_gap = req_quiet ? 0 : $urandom_range(0, 16);
            end
            if (!req_bus.valid || req_taken) begin
                if (req_gap == 0 && words_to_send.size() > 0) begin
                    w = words_to_send.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.cmd         <= w.cmd;
                    req_bus.index       <= w.index;
                    req_bus.entry_value <= w.entry_value;
                    req_bus.pixel       <= w.pixel;
                end else begin
                    req_bus.valid <= 1'b0;
                    if (req_gap > 0)
                        req_gap--;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n) begin
            if (rsp_taken) begin
                if ($urandom_range(0, 15) == 0)
                    rsp_quiet = !rsp_quiet;
                rsp_stall = rsp_quiet ? 0 : $urandom_range(0, 16);
            end
            if (rsp_stall > 0) begin
                rsp_bus.ready <= 1'b0;
                rsp_stall--;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted words, then check accepted results
    always @(posedge clk)
    begin
        hmm_word_t w;
        level_t    want;
        req_taken <= req_bus.valid && req_bus.ready;
        rsp_taken <= rsp_bus.valid && rsp_bus.ready;
        if (rst_n && req_bus.valid && req_bus.ready) begin
            w.cmd         = req_bus.cmd;
            w.index       = req_bus.index;
            w.entry_value = req_bus.entry_value;
            w.pixel       = req_bus.pixel;
            apply_word(w);
        end
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (mapped_due.size() == 0) begin
                $error("mapped_pixel: expected none, got %0d", rsp_bus.mapped_pixel);
                fault_count++;
            end else begin
                want = mapped_due.pop_front();
                if (rsp_bus.mapped_pixel !== want) begin
                    $error("mapped_pixel: expected %0d, got %0d", want, rsp_bus.mapped_pixel);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("histogram_matching_mapper verification failed");
            $finish;
        end
    end

    initial
    begin
        req_bus.valid       = 1'b0;
        req_bus.cmd         = CMD_LOAD_IN;
        req_bus.index       = '0;
        req_bus.entry_value = '0;
        req_bus.pixel       = '0;
        rsp_bus.ready       = 1'b0;
        rst_n               = 1'b0;
        for (int i = 0; i < 256; i++) begin
            in_eq[i]     = '0;
            ref_eq[i]    = '0;
            match_lut[i] = '0;
        end

        // match table reads zero before any build
        send_map(0);
        send_map(255);
        send_map(1);
        send_map(128);
        send_map($urandom_range(0, 255));

        // T = identity, G in steps of four: exact hits and ties towards lower z
        for (int i = 0; i < 256; i++) begin
            send_load(CMD_LOAD_IN, i, i);
            send_load(CMD_LOAD_REF, i, i & 8'hFC);
        end
        send_build();
        for (int p = 0; p <= 6; p++)
            send_map(p);
        send_map(127);
        send_map(128);
        send_map(253);
        send_map(254);
        send_map(255);
        for (int i = 0; i < 10; i++)
            send_map($urandom_range(0, 255));

        // G nearly flat at the top: first candidate has a large distance
        for (int i = 0; i < 256; i++)
            send_load(CMD_LOAD_REF, i, (i == 255) ? 254 : 255);
        send_build();
        send_map(0);
        send_map(254);
        send_map(255);
        send_map(128);
        for (int i = 0; i < 8; i++)
            send_map($urandom_range(0, 255));

        // fully random T
        for (int i = 0; i < 256; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_map($urandom_range(0, 255));
            send_load(CMD_LOAD_IN, i, $urandom_range(0, 255));
        end
        send_build();
        for (int i = 0; i < 50; i++)
            send_map($urandom_range(0, 255));

        queue_random_round(255);
        queue_random_round(15);
        queue_random_round(255);
        queue_random_round(3);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_to_send.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (mapped_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fault_count == 0 && mapped_due.size() == 0)
            $display("histogram_matching_mapper verification clean");
        else
            $display("histogram_matching_mapper verification failed");
        $finish;
    end

endmodule
